### hdl/cdsg_pkg.sv
// Shared types, constants and the exp2 constant table for the density splat grid.
`timescale 1ns / 1ps
package cdsg_pkg;

  localparam int IDX_W  = 16;  // widest cell index (256 x 256 grid)
  localparam int W_W    = 17;  // weight, Q16, up to 1.0
  localparam int DV_W   = 26;  // weighted velocity, Q16 style sum increment
  localparam int DEN_W  = 32;
  localparam int SUM_W  = 40;
  localparam int QDEPTH = 4;   // command queue depth, power of two

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SPLAT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ADD,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic                     hit;   // read cell lies inside the grid
    logic [IDX_W-1:0]         idx;
    logic [W_W-1:0]           w;
    logic signed [DV_W-1:0]   dvx;
    logic signed [DV_W-1:0]   dvy;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_LOG,
    F_CELL,
    F_MUL,
    F_EXP,
    F_WGT,
    F_SCALE,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ADD,
    B_RDATA,
    B_DIVSET,
    B_DIV,
    B_DEND,
    B_OUT
  } back_state_t;

  typedef logic [29:0] exp_tab_t [17];

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] nn;
    r  = 64'd0;
    b  = 64'd1 << 62;
    nn = n;
    for (int j = 0; j < 32; j++) begin
      if (b > nn) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (nn >= r + b) begin
          nn = nn - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // c[k] = 2^(-2^-k) in Q30, each entry the floored root of the one before
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    t[0] = 30'd1 << 29;
    for (int k = 1; k < 17; k++) begin
      t[k] = 30'(isqrt64({34'd0, t[k-1]} << 30));
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_C = build_exp_tab();

endpackage

### hdl/cdsg_fifo.sv
// Short command queue between the front classifier and the grid back end.
`timescale 1ns / 1ps
module cdsg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  cdsg_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output cdsg_pkg::cmd_t rdata,
  output logic          valid
);
  import cdsg_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          slot [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign valid = (count != '0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd && valid) begin
        rptr <= rptr + 1'b1;
      end
      if ((wr && !full) && !(rd && valid)) begin
        count <= count + 1'b1;
      end else if (!(wr && !full) && (rd && valid)) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slot[wptr] <= wdata;
    end
  end

endmodule

### hdl/cdsg_front.sv
// Front end: takes items, computes splat weights with a shared log2/exp2 sequencer.
`timescale 1ns / 1ps
module cdsg_front #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  ready,
  input  logic [1:0]            opcode,
  input  logic [13:0]           pos_x,
  input  logic [13:0]           pos_y,
  input  logic signed [15:0]    vel_x,
  input  logic signed [15:0]    vel_y,
  input  logic [16:0]           density_share,
  input  logic [5:0]            cell_x,
  input  logic [5:0]            cell_y,
  input  logic                  q_full,
  output logic                  q_push,
  output cdsg_pkg::cmd_t        q_data
);
  import cdsg_pkg::*;

  front_state_t state, state_next;

  logic [5:0]          fx, fy;
  logic [7:0]          dx, dy;
  logic [6:0]          cx, cy;
  logic                left, right, bot, top;
  logic signed [15:0]  vx, vy;
  logic [20:0]         ls;
  logic [19:0]         lm;
  logic [1:0]          corner;
  logic                log_share;
  logic [16:0]         lg_y;
  logic [4:0]          lg_k;
  logic [15:0]         lg_frac;
  logic [3:0]          cnt;
  logic [7:0]          t_i;
  logic [15:0]         t_f;
  logic [30:0]         ex_r;
  logic [16:0]         w;
  cmd_t                cmd;

  // per-cell selection
  logic [6:0]  sel_x, sel_y;
  logic        sel_en;
  logic [8:0]  sel_m;
  logic        sel_use;
  logic [8:0]  nx, ny, px, py;

  assign nx = 9'd256 - {1'b0, dx};
  assign ny = 9'd256 - {1'b0, dy};
  assign px = {1'b0, dx};
  assign py = {1'b0, dy};

  function automatic logic [8:0] umin9(input logic [8:0] a, input logic [8:0] b);
    return (a < b) ? a : b;
  endfunction

  always_comb begin
    unique case (corner)
      2'd0: begin
        sel_x = {1'b0, fx}; sel_y = cy; sel_en = !left && !top;  sel_m = umin9(nx, py);
      end
      2'd1: begin
        sel_x = cx; sel_y = {1'b0, fy}; sel_en = !bot && !right; sel_m = umin9(px, ny);
      end
      2'd2: begin
        sel_x = {1'b0, fx}; sel_y = {1'b0, fy}; sel_en = !left && !bot; sel_m = umin9(nx, ny);
      end
      default: begin
        sel_x = cx; sel_y = cy; sel_en = !right && !top; sel_m = umin9(px, py);
      end
    endcase
    sel_use = sel_en && (32'(sel_x) < GRID_W) && (32'(sel_y) < GRID_H);
  end

  // log2 operand and one square-and-compare step
  logic [16:0] share_c;
  logic [16:0] lg_x;
  logic [4:0]  lead_k;
  logic [32:0] norm_w;
  logic [33:0] sq;
  logic [17:0] ys;
  logic        lg_bit;
  logic [16:0] lg_y_step;
  logic [15:0] frac_step;
  logic [20:0] lg_val;

  always_comb begin
    if (density_share == 17'd0) share_c = 17'd1;
    else if (density_share > 17'd65536) share_c = 17'd65536;
    else share_c = density_share;
  end

  assign lg_x = (state == F_IDLE) ? share_c : {8'd0, sel_m};

  always_comb begin
    lead_k = 5'd0;
    for (int b = 0; b < 17; b++) begin
      if (lg_x[b]) lead_k = 5'(b);
    end
  end

  assign norm_w    = {16'd0, lg_x} << (5'd16 - lead_k);
  assign sq        = lg_y * lg_y;
  assign ys        = sq[33:16];
  assign lg_bit    = ys[17];
  assign lg_y_step = lg_bit ? ys[17:1] : ys[16:0];
  assign frac_step = {lg_frac[14:0], lg_bit};
  assign lg_val    = {lg_k, frac_step};

  // exp2 datapath
  logic [40:0] t_prod;
  logic [60:0] ex_prod;
  logic [31:0] w_rnd;
  logic [31:0] w_sh;
  logic signed [33:0] pvx, pvy;

  assign t_prod  = ls * lm;
  assign ex_prod = ex_r * EXP_C[5'(cnt) + 5'd1];
  assign w_rnd   = {1'b0, ex_r} + (32'd1 << (5'd13 + t_i[4:0]));
  assign w_sh    = w_rnd >> (5'd14 + t_i[4:0]);
  assign pvx     = $signed({1'b0, w}) * vx;
  assign pvy     = $signed({1'b0, w}) * vy;

  // read index
  logic [IDX_W-1:0] rd_idx;
  logic             rd_hit;
  assign rd_hit = (32'(cell_x) < GRID_W) && (32'(cell_y) < GRID_H);
  assign rd_idx = IDX_W'(32'(cell_y) * GRID_W + 32'(cell_x));

  logic [IDX_W-1:0] add_idx;
  assign add_idx = IDX_W'(32'(sel_y) * GRID_W + 32'(sel_x));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          unique case (opcode_t'(opcode))
            OP_SPLAT: state_next = F_LOG;
            OP_CLEAR: state_next = F_PUSH;
            OP_READ:  state_next = F_PUSH;
            default:  state_next = F_IDLE;
          endcase
        end
      end
      F_LOG: begin
        if (cnt == 4'd15) state_next = log_share ? F_CELL : F_MUL;
      end
      F_CELL: begin
        if (!sel_use) state_next = (corner == 2'd3) ? F_IDLE : F_CELL;
        else if (sel_m == 9'd0) state_next = F_SCALE;
        else state_next = F_LOG;
      end
      F_MUL:   state_next = F_EXP;
      F_EXP: begin
        if (t_i >= 8'd17 || cnt == 4'd15) state_next = F_WGT;
      end
      F_WGT:   state_next = F_SCALE;
      F_SCALE: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_next = (cmd.kind == CMD_ADD && corner != 2'd3) ? F_CELL : F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ready  = (state == F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
    q_data = cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          fx   <= pos_x[13:8];
          dx   <= pos_x[7:0];
          fy   <= pos_y[13:8];
          dy   <= pos_y[7:0];
          cx   <= {1'b0, pos_x[13:8]} + {6'd0, (pos_x[7:0] != 8'd0)};
          cy   <= {1'b0, pos_y[13:8]} + {6'd0, (pos_y[7:0] != 8'd0)};
          vx   <= vel_x;
          vy   <= vel_y;
          corner <= 2'd0;
          lg_y      <= norm_w[16:0];
          lg_k      <= lead_k;
          lg_frac   <= '0;
          cnt       <= '0;
          log_share <= 1'b1;
          cmd.hit <= rd_hit;
          cmd.idx <= rd_hit ? rd_idx : '0;
          cmd.w   <= '0;
          cmd.dvx <= '0;
          cmd.dvy <= '0;
          cmd.kind <= (opcode_t'(opcode) == OP_CLEAR) ? CMD_CLEAR : CMD_READ;
        end
      end
      F_LOG: begin
        lg_y    <= lg_y_step;
        lg_frac <= frac_step;
        cnt     <= cnt + 1'b1;
        if (cnt == 4'd15) begin
          if (log_share) begin
            ls   <= (21'd16 << 16) - lg_val;
            left  <= (cx == 7'd0);
            right <= (cx != 7'd0) && (32'(cx) >= GRID_W - 1);
            bot   <= (cy == 7'd0);
            top   <= (cy != 7'd0) && (32'(cy) >= GRID_H - 1);
          end else begin
            lm <= 20'((21'd8 << 16) - lg_val);
          end
        end
      end
      F_CELL: begin
        if (!sel_use) begin
          corner <= corner + 1'b1;
        end else begin
          cmd.kind <= CMD_ADD;
          cmd.hit  <= 1'b1;
          cmd.idx  <= add_idx;
          w        <= (ls == 21'd0) ? 17'd65536 : 17'd0;
          lg_y      <= norm_w[16:0];
          lg_k      <= lead_k;
          lg_frac   <= '0;
          cnt       <= '0;
          log_share <= 1'b0;
        end
      end
      F_MUL: begin
        t_i  <= t_prod[39:32];
        t_f  <= t_prod[31:16];
        ex_r <= 31'd1 << 30;
        cnt  <= '0;
      end
      F_EXP: begin
        if (t_f[4'd15 - cnt]) ex_r <= ex_prod[60:30];
        cnt <= cnt + 1'b1;
      end
      F_WGT: begin
        w <= (t_i >= 8'd17) ? 17'd0 : w_sh[16:0];
      end
      F_SCALE: begin
        cmd.w   <= w;
        cmd.dvx <= pvx[33:8];
        cmd.dvy <= pvy[33:8];
      end
      F_PUSH: begin
        if (!q_full && cmd.kind == CMD_ADD) corner <= corner + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hdl/cdsg_back.sv
// Back end: grid memory, clearing sweep, saturating accumulate and averaging divider.
`timescale 1ns / 1ps
module cdsg_back #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  cdsg_pkg::cmd_t     q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               res_valid,
  output logic [31:0]        density,
  output logic signed [15:0] avg_vel_x,
  output logic signed [15:0] avg_vel_y,
  output logic               cell_empty,
  output logic               init_busy
);
  import cdsg_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int MW    = DEN_W + 2 * SUM_W;

  back_state_t state, state_next;

  logic [MW-1:0] mem [CELLS];
  logic [MW-1:0] rd_data;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;

  logic [AW-1:0] sweep_addr;
  cmd_t          cmd;
  logic [47:0]   rem;
  logic [14:0]   quo;
  logic [3:0]    bitc;
  logic          sel_y;
  logic          neg;
  logic          sat;
  logic          rd_empty;
  logic signed [15:0] avg_x;
  logic signed [15:0] avg_y;

  logic [31:0]        den;
  logic signed [39:0] sx, sy;
  assign den = rd_data[MW-1 -: DEN_W];
  assign sx  = rd_data[2*SUM_W-1 -: SUM_W];
  assign sy  = rd_data[SUM_W-1:0];

  // saturating accumulate
  logic [32:0]        dsum;
  logic [31:0]        den_n;
  logic signed [40:0] xsum, ysum;
  logic signed [39:0] sx_n, sy_n;

  assign dsum  = {1'b0, den} + 33'(cmd.w);
  assign den_n = dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
  assign xsum  = {sx[39], sx} + {{15{cmd.dvx[DV_W-1]}}, cmd.dvx};
  assign ysum  = {sy[39], sy} + {{15{cmd.dvy[DV_W-1]}}, cmd.dvy};

  always_comb begin
    if (xsum[40] != xsum[39]) sx_n = xsum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    else sx_n = xsum[39:0];
    if (ysum[40] != ysum[39]) sy_n = ysum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    else sy_n = ysum[39:0];
  end

  // divider setup and step
  logic signed [39:0] s_sel;
  logic [40:0]        mag;
  logic [47:0]        num;
  logic [47:0]        dsh;
  logic [15:0]        qres;

  assign s_sel = sel_y ? sy : sx;
  assign mag   = s_sel[39] ? (41'd0 - {s_sel[39], s_sel}) : {1'b0, s_sel};
  assign num   = {mag[39:0], 8'd0};
  assign dsh   = {16'd0, den} << bitc;

  always_comb begin
    if (sat) qres = neg ? 16'h8000 : 16'h7FFF;
    else     qres = neg ? (16'd0 - {1'b0, quo}) : {1'b0, quo};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR:  if (sweep_addr == AW'(CELLS - 1)) state_next = B_IDLE;
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_data.kind)
            CMD_CLEAR: state_next = B_CLEAR;
            CMD_ADD:   state_next = B_ADD;
            CMD_READ:  state_next = B_RDATA;
            default:   state_next = B_IDLE;
          endcase
        end
      end
      B_ADD:    state_next = B_IDLE;
      B_RDATA:  state_next = (!cmd.hit || den == 32'd0) ? B_OUT : B_DIVSET;
      B_DIVSET: state_next = (num >= {1'b0, den, 15'd0}) ? B_DEND : B_DIV;
      B_DIV:    if (bitc == 4'd0) state_next = B_DEND;
      B_DEND:   state_next = sel_y ? B_OUT : B_DIVSET;
      B_OUT:    if (!res_valid) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // memory controls and queue pop
  always_comb begin
    q_pop  = (state == B_IDLE) && q_valid;
    mem_re = (state == B_IDLE) && q_valid;
    mem_we = (state == B_CLEAR) || (state == B_ADD);
    mem_wa = (state == B_CLEAR) ? sweep_addr : AW'(cmd.idx);
    mem_wd = (state == B_CLEAR) ? '0 : {den_n, sx_n, sy_n};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[AW'(q_data.idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      sweep_addr <= '0;
      init_busy  <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == AW'(CELLS - 1)) init_busy <= 1'b0;
      end else begin
        sweep_addr <= '0;
      end
      if (state == B_OUT && !res_valid) res_valid <= 1'b1;
      else if (pop && res_valid)        res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE:  if (q_valid) cmd <= q_data;
      B_RDATA: begin
        rd_empty <= !cmd.hit || den == 32'd0;
        sel_y    <= 1'b0;
      end
      B_DIVSET: begin
        neg  <= s_sel[39];
        sat  <= (num >= {1'b0, den, 15'd0});
        rem  <= num;
        quo  <= '0;
        bitc <= 4'd14;
      end
      B_DIV: begin
        if (rem >= dsh) begin
          rem       <= rem - dsh;
          quo[bitc] <= 1'b1;
        end
        bitc <= bitc - 1'b1;
      end
      B_DEND: begin
        if (sel_y) avg_y <= qres;
        else       avg_x <= qres;
        sel_y <= 1'b1;
      end
      B_OUT: begin
        if (!res_valid) begin
          density    <= rd_empty ? 32'd0 : den;
          avg_vel_x  <= rd_empty ? 16'sd0 : avg_x;
          avg_vel_y  <= rd_empty ? 16'sd0 : avg_y;
          cell_empty <= rd_empty;
        end
      end
      default: ;
    endcase
  end

endmodule

### hdl/crowd_density_splat_grid_unit.sv
// Top level of the crowd density splat grid: front, command queue and grid back end.
// A read passes the front's push state, the queue and the back end's read state, then, for an
//   in-grid occupied cell, the averaging divisions (15 quotient steps each); a clear sweeps
//   GRID_W*GRID_H cells. The front takes one item at a time; a splat runs the share log2, then
//   per written cell a log2, multiply, exp2 and scaling, only the scaling at zero distance.
// Reset: synchronous, active high; a clearing pass then zeroes every cell, full held high.
`timescale 1ns / 1ps
module crowd_density_splat_grid_unit #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         opcode,
  input  logic [13:0]        pos_x,
  input  logic [13:0]        pos_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic [16:0]        density_share,
  input  logic [5:0]         cell_x,
  input  logic [5:0]         cell_y,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        density,
  output logic signed [15:0] avg_vel_x,
  output logic signed [15:0] avg_vel_y,
  output logic               cell_empty
);
  import cdsg_pkg::*;

  logic  front_ready;
  logic  init_busy;
  logic  in_valid;
  logic  q_push, q_full, q_valid, q_pop;
  cmd_t  q_wdata, q_rdata;
  logic  res_valid;

  // items are held off while the post-reset clearing pass runs
  assign full     = init_busy || !front_ready;
  assign in_valid = push && !full;
  assign empty    = !res_valid;

  cdsg_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .ready         (front_ready),
    .opcode        (opcode),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .density_share (density_share),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  // one beat per command: clear, per-cell add, or read
  cdsg_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  cdsg_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .pop        (pop),
    .res_valid  (res_valid),
    .density    (density),
    .avg_vel_x  (avg_vel_x),
    .avg_vel_y  (avg_vel_y),
    .cell_empty (cell_empty),
    .init_busy  (init_busy)
  );

endmodule

### hdl/cdsg_checker.sv
// Port-level checks for the density splat grid, bound to the top level.
`timescale 1ns / 1ps
module cdsg_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [31:0]        density,
  input logic signed [15:0] avg_vel_x,
  input logic signed [15:0] avg_vel_y,
  input logic               cell_empty
);

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> full)
    else $error("input open during clearing pass");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && cell_empty) |-> (density == 32'd0 && avg_vel_x == 16'sd0 && avg_vel_y == 16'sd0))
    else $error("empty cell beat carries nonzero data");

  a_full_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !cell_empty) |-> (density != 32'd0))
    else $error("occupied cell beat with zero density");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(density) && $stable(cell_empty)))
    else $error("waiting result changed");

endmodule

bind crowd_density_splat_grid_unit cdsg_checker u_cdsg_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .density    (density),
  .avg_vel_x  (avg_vel_x),
  .avg_vel_y  (avg_vel_y),
  .cell_empty (cell_empty)
);
